FILE: hw/rtl/tftpc_pkg.sv
package tftpc_pkg;

  localparam int unsigned BLOCK_SIZE  = 512;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] WKP_RESET     = 16'd69;

  localparam logic [15:0] OPC_DATA  = 16'd3;
  localparam logic [15:0] OPC_ACK   = 16'd4;
  localparam logic [15:0] OPC_ERROR = 16'd5;

  // TFTP error codes placed in outgoing ERROR frames
  localparam logic [3:0] ERR_ACCESS      = 4'd2;
  localparam logic [3:0] ERR_DISK_FULL   = 4'd3;
  localparam logic [3:0] ERR_ILLEGAL_OP  = 4'd4;
  localparam logic [3:0] ERR_UNKNOWN_TID = 4'd5;
  localparam logic [15:0] SRV_CODE_MAX   = 16'd8;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_WKP       = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_PACKET = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_START,
    EV_TICK,
    EV_DATA,
    EV_ACK,
    EV_SRV_ERR,
    EV_ILLEGAL,
    EV_IGNORE
  } event_t;

  typedef enum logic [2:0] {
    SEND_NONE = 3'd0,
    SEND_REQ  = 3'd1,
    SEND_ACK  = 3'd2,
    SEND_DATA = 3'd3,
    SEND_ERR  = 3'd4
  } send_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_OK      = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_SERVER  = 3'd3,
    ST_PROTO   = 3'd4,
    ST_LOCAL   = 3'd5
  } status_t;

  typedef struct packed {
    logic        direction;
    logic [15:0] timeout_ticks;
    logic [15:0] well_known_port;
  } cfg_t;

  // classified event word passed from front to back
  typedef struct packed {
    event_t      ev;
    logic [15:0] blk_num;
    logic [9:0]  len;
    logic        short_blk;
    logic [15:0] src_port;
    logic        local_error;
    logic [3:0]  srv_code;
  } ev_word_t;

endpackage

FILE: hw/rtl/tftp_client_transfer_control.sv
// TFTP client transfer controller.
// Input channel (in_valid/in_ready): one event word per handshake - start, a
// millisecond tick, or the header of a received packet. Output channel
// (out_valid/out_ready): exactly one result word per event, saying which
// frame to send next and how the transfer stands.
// Configuration over APB: direction at 0x0, timeout_ticks at 0x4,
// well_known_port at 0x8. pready is tied high; write only while no event
// is in flight.
// Results are registered: an accepted event is written into the event queue,
// and its result word is written into the output register once that register
// is empty or its word is being taken.
// Throughput: one event per cycle while out_ready is high, set by the state
// update in the back end.
// Reset: phase idle, block number and tick count cleared, server port 69,
// registers at their defaults; queue and output register empty.
// When the receiver stalls, the result holds in the output register, the
// back end stops draining the queue and in_ready drops once QUEUE_DEPTH
// events are waiting.
module tftp_client_transfer_control import tftpc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = tftpc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [15:0]       in_opcode,
  input  logic [15:0]       in_block_num,
  input  logic [9:0]        in_payload_len,
  input  logic [15:0]       in_src_port,
  input  logic [9:0]        in_local_len,
  input  logic              in_local_error,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_send_kind,
  output logic [15:0]       out_out_block,
  output logic [9:0]        out_out_len,
  output logic [3:0]        out_error_code,
  output logic [15:0]       out_dest_port,
  output logic              out_done_res,
  output logic [2:0]        out_status,
  output logic [25:0]       out_total_bytes,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg_r;
  logic     cfg_wr;
  reg_idx_t reg_idx;

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_valid;
  ev_word_t q_wdata;
  ev_word_t q_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction       <= 1'b0;
      cfg_r.timeout_ticks   <= TIMEOUT_RESET;
      cfg_r.well_known_port <= WKP_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DIRECTION: cfg_r.direction       <= pwdata[0];
        REG_TIMEOUT:   cfg_r.timeout_ticks   <= pwdata[15:0];
        REG_WKP:       cfg_r.well_known_port <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIRECTION: prdata = {31'b0, cfg_r.direction};
      REG_TIMEOUT:   prdata = {16'b0, cfg_r.timeout_ticks};
      REG_WKP:       prdata = {16'b0, cfg_r.well_known_port};
      default:       prdata = '0;
    endcase
  end

  tftpc_front u_front (
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_opcode      (in_opcode),
    .in_block_num   (in_block_num),
    .in_payload_len (in_payload_len),
    .in_src_port    (in_src_port),
    .in_local_len   (in_local_len),
    .in_local_error (in_local_error),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_word         (q_wdata)
  );

  tftpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  tftpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_word          (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_send_kind   (out_send_kind),
    .out_out_block   (out_out_block),
    .out_out_len     (out_out_len),
    .out_error_code  (out_error_code),
    .out_dest_port   (out_dest_port),
    .out_done_res    (out_done_res),
    .out_status      (out_status),
    .out_total_bytes (out_total_bytes)
  );

endmodule

FILE: hw/rtl/tftpc_front.sv
module tftpc_front import tftpc_pkg::*; (
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_block_num,
  input  logic [9:0]  in_payload_len,
  input  logic [15:0] in_src_port,
  input  logic [9:0]  in_local_len,
  input  logic        in_local_error,
  input  logic        q_full,
  output logic        q_push,
  output ev_word_t    q_word
);

  localparam logic [16:0] BS = 17'(BLOCK_SIZE);

  logic [16:0] loc_len17;
  logic [16:0] loc_sat;
  logic [9:0]  len_sel;
  event_t      ev;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    ev = EV_IGNORE;
    case (cmd_t'(in_cmd))
      CMD_START: ev = EV_START;
      CMD_TICK:  ev = EV_TICK;
      CMD_PACKET: begin
        if (in_opcode == OPC_DATA && !cfg.direction) begin
          ev = EV_DATA;
        end else if (in_opcode == OPC_ACK && cfg.direction) begin
          ev = EV_ACK;
        end else if (in_opcode == OPC_ERROR) begin
          ev = EV_SRV_ERR;
        end else begin
          ev = EV_ILLEGAL;
        end
      end
      default: ev = EV_IGNORE;
    endcase
  end

  // outgoing DATA length is clipped to the block size
  assign loc_len17 = {7'b0, in_local_len};
  assign loc_sat   = (loc_len17 > BS) ? BS : loc_len17;
  assign len_sel   = (ev == EV_DATA) ? in_payload_len : loc_sat[9:0];

  always_comb begin
    q_word.ev          = ev;
    q_word.blk_num     = in_block_num;
    q_word.len         = len_sel;
    q_word.short_blk   = ({7'b0, len_sel} < BS);
    q_word.src_port    = in_src_port;
    q_word.local_error = in_local_error;
    q_word.srv_code    = (in_block_num <= SRV_CODE_MAX) ? in_block_num[3:0] : 4'd0;
  end

endmodule

FILE: hw/rtl/tftpc_queue.sv
module tftpc_queue import tftpc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ev_word_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output ev_word_t rdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ev_word_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/tftpc_back.sv
module tftpc_back import tftpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  ev_word_t    q_word,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_send_kind,
  output logic [15:0] out_out_block,
  output logic [9:0]  out_out_len,
  output logic [3:0]  out_error_code,
  output logic [15:0] out_dest_port,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [25:0] out_total_bytes
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] block_r, block_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] sport_r, sport_nxt;
  status_t     status_r, status_nxt;

  logic        out_valid_r;
  send_t       kind_r, kind_nxt;
  logic [15:0] oblock_r, oblock_nxt;
  logic [9:0]  olen_r, olen_nxt;
  logic [3:0]  ecode_r, ecode_nxt;
  logic [15:0] dport_r;
  logic        done_r;
  status_t     ostat_r;
  logic [25:0] total_r, total_nxt;

  logic [15:0] block_inc;
  logic [25:0] full_bytes;
  logic        in_wait;
  logic        is_packet;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign block_inc = block_r + 16'd1;
  assign in_wait   = (phase_r == PH_WAIT);
  assign is_packet = (q_word.ev == EV_DATA) || (q_word.ev == EV_ACK) ||
                     (q_word.ev == EV_SRV_ERR) || (q_word.ev == EV_ILLEGAL);

  // whole blocks before the final one always number block_r
  assign full_bytes = 26'(block_r) * 26'(BLOCK_SIZE);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    block_nxt   = block_r;
    elapsed_nxt = elapsed_r;
    sport_nxt   = sport_r;
    status_nxt  = status_r;
    if (q_word.ev == EV_START) begin
      phase_nxt   = PH_WAIT;
      block_nxt   = '0;
      elapsed_nxt = '0;
      sport_nxt   = cfg.well_known_port;
      status_nxt  = ST_BUSY;
    end else if (in_wait) begin
      if (is_packet && sport_r == cfg.well_known_port) begin
        sport_nxt = q_word.src_port;
      end
      case (q_word.ev)
        EV_TICK: begin
          if (elapsed_r >= cfg.timeout_ticks) begin
            phase_nxt  = PH_DONE;
            status_nxt = ST_TIMEOUT;
          end else begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
        end
        EV_DATA: begin
          block_nxt = block_inc;
          if (q_word.blk_num != block_inc) begin
            phase_nxt  = PH_DONE;
            status_nxt = ST_PROTO;
          end else if (q_word.local_error) begin
            phase_nxt  = PH_DONE;
            status_nxt = ST_LOCAL;
          end else begin
            elapsed_nxt = '0;
            if (q_word.short_blk) begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_OK;
            end
          end
        end
        EV_ACK: begin
          if (q_word.blk_num != block_r) begin
            phase_nxt  = PH_DONE;
            status_nxt = ST_PROTO;
          end else if (q_word.local_error) begin
            phase_nxt  = PH_DONE;
            status_nxt = ST_LOCAL;
          end else begin
            block_nxt   = block_inc;
            elapsed_nxt = '0;
            if (q_word.short_blk) begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_OK;
            end
          end
        end
        EV_SRV_ERR: begin
          phase_nxt  = PH_DONE;
          status_nxt = ST_SERVER;
        end
        EV_ILLEGAL: begin
          phase_nxt  = PH_DONE;
          status_nxt = ST_PROTO;
        end
        default: ;
      endcase
    end
  end

  // result word
  always_comb begin
    kind_nxt   = SEND_NONE;
    oblock_nxt = '0;
    olen_nxt   = '0;
    ecode_nxt  = '0;
    total_nxt  = '0;
    if (q_word.ev == EV_START) begin
      kind_nxt = SEND_REQ;
    end else if (in_wait) begin
      case (q_word.ev)
        EV_DATA: begin
          if (q_word.blk_num != block_inc) begin
            kind_nxt  = SEND_ERR;
            ecode_nxt = ERR_UNKNOWN_TID;
          end else if (q_word.local_error) begin
            kind_nxt  = SEND_ERR;
            ecode_nxt = ERR_DISK_FULL;
          end else begin
            kind_nxt   = SEND_ACK;
            oblock_nxt = block_inc;
            if (q_word.short_blk) begin
              total_nxt = full_bytes + {16'b0, q_word.len};
            end
          end
        end
        EV_ACK: begin
          if (q_word.blk_num != block_r) begin
            kind_nxt  = SEND_ERR;
            ecode_nxt = ERR_UNKNOWN_TID;
          end else if (q_word.local_error) begin
            kind_nxt  = SEND_ERR;
            ecode_nxt = ERR_ACCESS;
          end else begin
            kind_nxt   = SEND_DATA;
            oblock_nxt = block_inc;
            olen_nxt   = q_word.len;
            if (q_word.short_blk) begin
              total_nxt = full_bytes + {16'b0, q_word.len};
            end
          end
        end
        EV_SRV_ERR: ecode_nxt = q_word.srv_code;
        EV_ILLEGAL: begin
          kind_nxt  = SEND_ERR;
          ecode_nxt = ERR_ILLEGAL_OP;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      block_r     <= '0;
      elapsed_r   <= '0;
      sport_r     <= WKP_RESET;
      status_r    <= ST_BUSY;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r   <= phase_nxt;
        block_r   <= block_nxt;
        elapsed_r <= elapsed_nxt;
        sport_r   <= sport_nxt;
        status_r  <= status_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= kind_nxt;
      oblock_r <= oblock_nxt;
      olen_r   <= olen_nxt;
      ecode_r  <= ecode_nxt;
      dport_r  <= sport_nxt;
      done_r   <= (phase_nxt == PH_DONE);
      ostat_r  <= status_nxt;
      total_r  <= total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_send_kind   = kind_r;
  assign out_out_block   = oblock_r;
  assign out_out_len     = olen_r;
  assign out_error_code  = ecode_r;
  assign out_dest_port   = dport_r;
  assign out_done_res    = done_r;
  assign out_status      = ostat_r;
  assign out_total_bytes = total_r;

  a_done_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) == (status_r != ST_BUSY))
    else $error("phase and final status disagree");

  a_start_sends_req: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_word.ev == EV_START) |=> (out_valid_r && kind_r == SEND_REQ &&
      phase_r == PH_WAIT))
    else $error("start did not issue a request");

  a_err_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == SEND_ERR) |-> (done_r && ecode_r != 4'd0 &&
      (ostat_r == ST_PROTO || ostat_r == ST_LOCAL)))
    else $error("error frame without a terminal status");

  a_total_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && total_r != '0) |-> (done_r && ostat_r == ST_OK))
    else $error("byte total reported on an incomplete transfer");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> ($stable(block_r) && $stable(sport_r) && $stable(phase_r)))
    else $error("transfer state moved without an event");

endmodule
